// File: rtl/wfg_pkg.sv
// Package for the wait-for graph deadlock detector.
// Holds payload structs, table entry type and sizing constants; no dependencies.
package wfg_pkg;

    localparam int MaxProcsDef = 16;
    localparam int ResIdBitsDef = 6;
    localparam int MaxSitesDef = 16;

    typedef struct packed {
        logic       action;
        logic [3:0] process_index;
        logic       hold_valid;
        logic [5:0] hold_resource;
        logic [4:0] hold_site;
        logic       wait_valid;
        logic [5:0] wait_resource;
        logic [4:0] wait_site;
    } cmd_t;

    typedef struct packed {
        logic [15:0] site_deadlock_mask;
        logic        any_cycle;
        logic        cross_site_wait;
        logic        global_deadlock;
    } result_t;

    typedef struct packed {
        logic       hold_valid;
        logic [5:0] hold_resource;
        logic [4:0] hold_site;
        logic       wait_valid;
        logic [5:0] wait_resource;
        logic [4:0] wait_site;
    } entry_t;

    localparam logic ActLoad = 1'b0;
    localparam logic ActEval = 1'b1;

endpackage

// File: rtl/wfg_cell.sv
// One process cell: holds a table entry and one row of the reachability matrix.
// Depends on wfg_pkg.
module wfg_cell #(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  wfg_pkg::entry_t      load_entry,
    input  logic                 active,
    input  logic [MAX_PROCS-1:0] hold_match_vec,
    input  logic                 build_en,
    input  logic                 close_en,
    input  logic [IDX_W-1:0]     pivot,
    input  logic [MAX_PROCS-1:0] pivot_row,
    output wfg_pkg::entry_t      entry,
    output logic [MAX_PROCS-1:0] row
);
    import wfg_pkg::*;

    entry_t               entry_reg;
    logic [MAX_PROCS-1:0] row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (load_en)
        begin
            entry_reg <= load_entry;
        end
    end

    // Build the direct edge row, then fold in the pivot's row (Warshall step).
    always_comb
    begin
        row_next = row_reg;
        if (build_en)
        begin
            row_next = (active && entry_reg.wait_valid) ? hold_match_vec : '0;
        end
        else if (close_en && row_reg[pivot])
        begin
            row_next = row_reg | pivot_row;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign entry = entry_reg;
    assign row   = row_reg;
endmodule

// File: rtl/wait_for_graph_deadlock_detector_unit.sv
// Top level of the wait-for graph deadlock detector: cell row and control.
// Depends on wfg_pkg and wfg_cell.
//
//  channel   signals                         direction  handshake
//  command   start, busy, cmd                in         start & !busy
//  result    result_valid, result            out        strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_data  in         valid & ready
//
// A load item writes its entry on acceptance. An evaluate item runs ST_BUILD
// (builds the edge rows), ST_CLOSE (closure passes for n = min(process_count,
// MAX_PROCS) pivots, one pivot per cycle over all cells) and ST_FINAL (forms
// the verdict); the result strobe is registered from ST_FINAL.
// Reset clears the table, the count (to 1) and the control state.
// The receiver cannot stall; busy is high during an evaluation.
module wait_for_graph_deadlock_detector_unit
    import wfg_pkg::*;
#(
    parameter int MAX_PROCS = MaxProcsDef,
    parameter int RESOURCE_ID_BITS = ResIdBitsDef,
    parameter int MAX_SITES = MaxSitesDef
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    result_valid,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic [4:0] cfg_data
);
    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    // Only the low RESOURCE_ID_BITS of an identifier take part in a compare.
    localparam logic [5:0] ResMask = 6'((64'd1 << RESOURCE_ID_BITS) - 64'd1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_CLOSE = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]       count_reg;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] pivot_reg, pivot_next;
    logic             valid_reg;
    result_t          result_reg;

    entry_t               entries [MAX_PROCS];
    logic [MAX_PROCS-1:0] rows [MAX_PROCS];
    logic [MAX_PROCS-1:0] match_vec [MAX_PROCS];
    logic [MAX_PROCS-1:0] active;

    logic accept;
    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;

    // Process count saturates at the table depth.
    assign n_eff = ({27'd0, count_reg} > MAX_PROCS) ? CNT_W'(MAX_PROCS)
                                                    : CNT_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // Hold-match vectors: entry i waits on what entry j holds (low id bits).
    always_comb
    begin
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            active[i] = (CNT_W'(i) < n_eff);
            for (int j = 0; j < MAX_PROCS; j++)
            begin
                match_vec[i][j] = (CNT_W'(j) < n_eff) && entries[j].hold_valid &&
                    (((entries[j].hold_resource ^ entries[i].wait_resource) & ResMask)
                     == 6'd0);
            end
        end
    end

    logic [IDX_W-1:0] pivot_idx;
    assign pivot_idx = pivot_reg[IDX_W-1:0];

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_cell
            entry_t le;
            assign le = '{cmd.hold_valid, cmd.hold_resource, cmd.hold_site,
                          cmd.wait_valid, cmd.wait_resource, cmd.wait_site};
            wfg_cell #(
                .MAX_PROCS(MAX_PROCS),
                .IDX_W(IDX_W)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .load_en(accept && cmd.action == ActLoad &&
                         {28'd0, cmd.process_index} == g),
                .load_entry(le),
                .active(active[g]),
                .hold_match_vec(match_vec[g]),
                .build_en(state_reg == ST_BUILD),
                .close_en(state_reg == ST_CLOSE),
                .pivot(pivot_idx),
                .pivot_row(rows[pivot_idx]),
                .entry(entries[g]),
                .row(rows[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        pivot_next = pivot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.action == ActEval)
                begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                pivot_next = '0;
                state_next = (n_eff == '0) ? ST_FINAL : ST_CLOSE;
            end
            ST_CLOSE:
            begin
                pivot_next = pivot_reg + 1'b1;
                if (pivot_reg + 1'b1 >= n_eff)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pivot_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pivot_reg <= pivot_next;
            valid_reg <= (state_reg == ST_FINAL);
        end
    end

    // Verdict from the diagonal of the closed matrix and the site fields of the entries.
    result_t verdict;
    always_comb
    begin
        logic both, cyc;
        verdict = '0;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            both = active[i] && entries[i].hold_valid && entries[i].wait_valid;
            cyc  = both && rows[i][i];
            if (both && entries[i].hold_site != entries[i].wait_site)
            begin
                verdict.cross_site_wait = 1'b1;
            end
            if (cyc)
            begin
                verdict.any_cycle = 1'b1;
                for (int s = 1; s <= 16; s++)
                begin
                    if (s <= MAX_SITES && entries[i].hold_site == entries[i].wait_site &&
                        entries[i].hold_site == 5'(s))
                    begin
                        verdict.site_deadlock_mask[s-1] = 1'b1;
                    end
                end
            end
        end
        verdict.global_deadlock = verdict.any_cycle && verdict.cross_site_wait;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINAL)
        begin
            result_reg <= verdict;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |=> result_valid)
        else $error("no result after verdict");
    a_glob: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.global_deadlock ==
                          (result.any_cycle && result.cross_site_wait)))
        else $error("global verdict mismatch");
endmodule

// File: sim/wait_for_graph_deadlock_detector_unit_test.sv
// Self-checking test of the wait-for graph deadlock detector top level.
// Depends on wfg_pkg and the detector RTL; predicts each verdict from a local copy of the table.
`timescale 1ns / 100ps

module wait_for_graph_deadlock_detector_unit_test;
    import wfg_pkg::*;

    localparam int NumProcs = 16;
    localparam int WatchLimit = 20000;
    localparam int CmdBits = $bits(cmd_t);

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    result_valid;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [4:0] cfg_data;

    // Local copy of the process table and of the count register.
    entry_t    table_copy [NumProcs];
    int        proc_count;
    result_t   verdict_queue [$];
    int        error_count;
    int        idle_cycles;
    int        send_idle_pct;
    bit        run_done;

    wait_for_graph_deadlock_detector_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Builds the verdict of one evaluation: edges from waiters to holders of the
    // same resource, a full transitive closure, then per-process cycle tests.
    function automatic result_t deadlock_verdict();
        logic [NumProcs-1:0] reach [NumProcs];
        int n;
        result_t v;
        logic both;
        n = (proc_count > NumProcs) ? NumProcs : proc_count;
        v = '0;
        for (int i = 0; i < NumProcs; i++)
        begin
            reach[i] = '0;
            if (i < n && table_copy[i].wait_valid)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (table_copy[j].hold_valid &&
                        table_copy[j].hold_resource == table_copy[i].wait_resource)
                        reach[i][j] = 1'b1;
                end
            end
        end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (reach[i][k])
                    reach[i] |= reach[k];
        for (int i = 0; i < n; i++)
        begin
            both = table_copy[i].hold_valid && table_copy[i].wait_valid;
            if (both && table_copy[i].hold_site != table_copy[i].wait_site)
                v.cross_site_wait = 1'b1;
            if (both && reach[i][i])
            begin
                v.any_cycle = 1'b1;
                // Sites 0 and above 16 take part in the cycle but set no mask bit.
                if (table_copy[i].hold_site == table_copy[i].wait_site &&
                    table_copy[i].hold_site >= 1 && table_copy[i].hold_site <= 16)
                    v.site_deadlock_mask[table_copy[i].hold_site - 1] = 1'b1;
            end
        end
        v.global_deadlock = v.any_cycle & v.cross_site_wait;
        return v;
    endfunction

    // Sends one item after a random gap; the model is updated at acceptance.
    // Start stays high after acceptance until the next gap or the end of sending.
    task automatic send_item(input cmd_t c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c.action == ActLoad)
            table_copy[c.process_index] = '{c.hold_valid, c.hold_resource, c.hold_site,
                                            c.wait_valid, c.wait_resource, c.wait_site};
        else
            verdict_queue.push_back(deadlock_verdict());
    endtask

    task automatic load_entry(input int idx, input bit hv, input int hr, input int hs,
                              input bit wv, input int wr, input int ws);
        cmd_t c;
        c = '{ActLoad, idx[3:0], hv, hr[5:0], hs[4:0], wv, wr[5:0], ws[4:0]};
        send_item(c);
    endtask

    task automatic evaluate();
        cmd_t c;
        c = CmdBits'($urandom());
        c.action = ActEval;
        send_item(c);
    endtask

    // Waits for outstanding verdicts plus the evaluation latency, then writes the count.
    task automatic write_count(input int value);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (verdict_queue.size() != 0 && guard < WatchLimit)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (NumProcs + 6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[4:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        proc_count = value;
    endtask

    // Random entry: resources drawn from a narrow pool most of the time so that
    // edges and cycles form; hold sites drawn mostly from 1..3, wait sites often equal to them, to hit same-site cases.
    task automatic load_random(input int idx);
        int hr, wr, hs, ws;
        hr = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(5);
        wr = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(5);
        hs = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 3);
        ws = ($urandom_range(1) == 0) ? hs : $urandom_range(31);
        load_entry(idx, $urandom_range(7) != 0, hr, hs, $urandom_range(7) != 0, wr, ws);
    endtask

    task automatic test_directed();
        write_count(16);
        evaluate();
        // Two-process cycle in site 5, then a self loop in site 16.
        load_entry(0, 1, 10, 5, 1, 11, 5);
        load_entry(1, 1, 11, 5, 1, 10, 5);
        evaluate();
        load_entry(15, 1, 63, 16, 1, 63, 16);
        evaluate();
        // A cross-site holder turns the cycle into a global deadlock.
        load_entry(2, 1, 0, 1, 1, 0, 31);
        evaluate();
        // Site zero on a cycle sets no mask bit.
        load_entry(3, 1, 20, 0, 1, 20, 0);
        load_entry(4, 0, 63, 31, 0, 63, 31);
        evaluate();
        write_count(0);
        evaluate();
        write_count(31);
        evaluate();
        write_count(1);
        evaluate();
        write_count(2);
        evaluate();
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                write_count($urandom_range(31));
            end
            n = (proc_count == 0) ? 1 : ((proc_count > NumProcs) ? NumProcs : proc_count);
            repeat ($urandom_range(1, 4))
            begin
                load_random($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(n - 1));
                sent++;
            end
            evaluate();
            sent++;
        end
    endtask

    // Every result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (verdict_queue.size() == 0)
            begin
                report_mismatch("unexpected result", int'(result), 0);
            end
            else
            begin
                result_t want;
                want = verdict_queue.pop_front();
                if (result.site_deadlock_mask != want.site_deadlock_mask)
                    report_mismatch("site_deadlock_mask", int'(result.site_deadlock_mask),
                                    int'(want.site_deadlock_mask));
                if (result.any_cycle != want.any_cycle)
                    report_mismatch("any_cycle", int'(result.any_cycle),
                                    int'(want.any_cycle));
                if (result.cross_site_wait != want.cross_site_wait)
                    report_mismatch("cross_site_wait", int'(result.cross_site_wait),
                                    int'(want.cross_site_wait));
                if (result.global_deadlock != want.global_deadlock)
                    report_mismatch("global_deadlock", int'(result.global_deadlock),
                                    int'(want.global_deadlock));
            end
        end
    end

    // Watchdog: counts cycles in which no item, result or register write is accepted.
    always @(posedge clk)
    begin
        if (!rst_n || run_done || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        run_done = 1'b0;
        proc_count = 1;
        send_idle_pct = 35;
        for (int i = 0; i < NumProcs; i++)
            table_copy[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(130);
        send_idle_pct = 45;
        test_random(130);
        send_idle_pct = 0;
        test_random(130);

        write_count(16);
        evaluate();
        start <= 1'b0;
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (NumProcs + 6) @(posedge clk);
        run_done = 1'b1;
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
